[rtl/qat_pkg.sv]
// Shared types and character constants for the quoted argument tokenizer.
`default_nettype none

package qat_pkg;

  // Character codes that the scanner reacts to.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Width of the packed result word on the output stream.
  localparam int unsigned RES_W = 32;

  // Scanner state.
  typedef enum logic [2:0] {
    SCAN_BETWEEN,
    SCAN_TOKEN,
    SCAN_ESCAPE,
    SCAN_QUOTED,
    SCAN_DONE
  } scan_e;

  // One classified character as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_zero;
    logic       is_blank;
    logic       is_lead;    // '!' or '$'
    logic       is_bslash;
    logic       is_quote;
  } chr_t;

  // Queue head handed to the back part.
  typedef struct packed {
    logic valid;
    chr_t chr;
  } head_t;

  // One result item.
  typedef struct packed {
    logic [7:0] tok_char;
    logic       char_valid;
    logic       token_end;
    logic       line_end;
    logic [4:0] token_count;
    logic       alt_valid;
    logic [7:0] alt_offset;
    logic       overflow;
  } res_t;

endpackage

`default_nettype wire

[rtl/qat_front.sv]
// Front part: accepts characters, classifies them and queues them for the scanner.
`default_nettype none

module qat_front
  import qat_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_ch_i,
  output head_t           head_o,
  input  wire logic       pop_i
);

  chr_t       chr_in;
  chr_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       pop;

  // Classify the incoming character.
  always_comb begin
    chr_in.ch        = in_ch_i;
    chr_in.is_zero   = (in_ch_i == CH_NUL);
    chr_in.is_blank  = (in_ch_i == CH_SPACE) || (in_ch_i == CH_TAB);
    chr_in.is_lead   = (in_ch_i == CH_BANG) || (in_ch_i == CH_DOLLAR);
    chr_in.is_bslash = (in_ch_i == CH_BSLASH);
    chr_in.is_quote  = (in_ch_i == CH_QUOTE);
  end

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (count_q != 2'd0);

  // Two-entry queue bookkeeping.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= chr_in;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.chr   = entry_q[rd_ptr_q];

endmodule

`default_nettype wire

[rtl/qat_back.sv]
// Back part: the token scanner and its output register.
`default_nettype none

module qat_back
  import qat_pkg::*;
#(
  parameter int unsigned MAX_TOKENS = 19,
  parameter int unsigned LINE_MAX   = 256
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  head_t      head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output res_t       out_res_o
);

  localparam int unsigned PW = $clog2(LINE_MAX + 1);
  localparam int unsigned CW = $clog2(MAX_TOKENS + 1);
  localparam int unsigned AW = (PW > 8) ? PW : 9;

  scan_e         state_q, state_d;
  logic          tn_q, tn_d;
  logic [1:0]    fp_q, fp_d;
  logic [PW-1:0] lp_q, lp_d;
  logic [CW-1:0] tok_q, tok_d;
  logic [PW-1:0] alt_q, alt_d;
  logic          alt_seen_q, alt_seen_d;
  logic          limit_q, limit_d;

  logic          out_valid_q, out_valid_d;
  res_t          res_q, res_d;

  chr_t          c;
  logic          do_put, do_close, force_done, ended;
  logic [7:0]    o_char;
  logic          o_valid, o_end;
  logic [CW-1:0] tok_out;
  logic          alt_seen_out;
  logic [PW-1:0] alt_out;
  logic          limit_out;
  logic [AW-1:0] alt_ext;

  assign c     = head_i.chr;
  assign pop_o = head_i.valid && (!out_valid_q || out_ready_i);

  // Scanner step: next state for one character.
  always_comb begin
    state_d    = state_q;
    tn_d       = tn_q;
    fp_d       = fp_q;
    lp_d       = lp_q;
    tok_d      = tok_q;
    alt_d      = alt_q;
    alt_seen_d = alt_seen_q;
    limit_d    = limit_q;
    do_put     = 1'b0;
    do_close   = 1'b0;
    force_done = 1'b0;
    ended      = 1'b0;
    o_char     = 8'h00;
    o_valid    = 1'b0;
    o_end      = 1'b0;

    if (c.is_zero) begin
      if (state_q == SCAN_TOKEN || state_q == SCAN_ESCAPE || state_q == SCAN_QUOTED) begin
        do_close = 1'b1;
      end
      ended = 1'b1;
    end else begin
      if (lp_q < PW'(LINE_MAX)) begin
        lp_d = lp_q + PW'(1);
      end
      if (state_q == SCAN_DONE) begin
        // Rest of the line is ignored.
      end else if (lp_q >= PW'(LINE_MAX)) begin
        limit_d    = 1'b1;
        do_close   = (state_q != SCAN_BETWEEN);
        force_done = 1'b1;
      end else if (lp_q == '0 && fp_q == 2'd0 && c.is_lead) begin
        do_put   = 1'b1;
        fp_d     = 2'd1;
        do_close = 1'b1;
      end else begin
        unique case (state_q)
          SCAN_BETWEEN: begin
            if (!c.is_blank) begin
              if (fp_q == 2'd0) begin
                fp_d = 2'd1;
              end else if (fp_q == 2'd1) begin
                fp_d       = 2'd2;
                alt_seen_d = 1'b1;
                alt_d      = lp_q;
              end
              if (c.is_bslash) state_d = SCAN_ESCAPE;
              else if (c.is_quote) state_d = SCAN_QUOTED;
              else begin
                state_d = SCAN_TOKEN;
                do_put  = 1'b1;
              end
            end
          end
          SCAN_TOKEN: begin
            if (c.is_blank) do_close = 1'b1;
            else if (c.is_bslash) state_d = SCAN_ESCAPE;
            else if (c.is_quote) state_d = SCAN_QUOTED;
            else do_put = 1'b1;
          end
          SCAN_ESCAPE: begin
            do_put  = 1'b1;
            state_d = SCAN_TOKEN;
          end
          SCAN_QUOTED: begin
            if (c.is_quote) state_d = SCAN_TOKEN;
            else do_put = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end

    // Append a character to the open token, or drop it past the token limit.
    if (do_put) begin
      tn_d = 1'b1;
      if (tok_q < CW'(MAX_TOKENS)) begin
        o_char  = c.ch;
        o_valid = 1'b1;
      end else begin
        limit_d = 1'b1;
      end
    end

    // Finish the open token; an empty one ends the list.
    if (do_close) begin
      if (tn_d) begin
        if (tok_d < CW'(MAX_TOKENS)) begin
          tok_d = tok_d + CW'(1);
          o_end = 1'b1;
        end
        state_d = SCAN_BETWEEN;
      end else begin
        if (fp_d == 2'd1) begin
          fp_d       = 2'd2;
          alt_seen_d = 1'b0;
        end
        state_d = SCAN_DONE;
      end
      tn_d = 1'b0;
    end

    // A line that ran too long stops scanning.
    if (force_done) begin
      if (fp_d == 2'd1) begin
        fp_d       = 2'd2;
        alt_seen_d = 1'b0;
      end
      state_d = SCAN_DONE;
    end

    // The result shows the state before the line end clears it.
    tok_out      = tok_d;
    alt_seen_out = alt_seen_d;
    alt_out      = alt_d;
    limit_out    = limit_d;

    if (ended) begin
      state_d    = SCAN_BETWEEN;
      tn_d       = 1'b0;
      fp_d       = 2'd0;
      lp_d       = '0;
      tok_d      = '0;
      alt_d      = '0;
      alt_seen_d = 1'b0;
      limit_d    = 1'b0;
    end
  end

  // Result formatting and output register control.
  always_comb begin
    alt_ext           = AW'(alt_out);
    res_d             = res_q;
    out_valid_d       = out_valid_q;
    if (pop_o) begin
      res_d.tok_char    = o_char;
      res_d.char_valid  = o_valid;
      res_d.token_end   = o_end;
      res_d.line_end    = ended;
      res_d.token_count = 5'(tok_out);
      res_d.alt_valid   = alt_seen_out;
      if (!alt_seen_out) res_d.alt_offset = 8'h00;
      else if (alt_ext > AW'(255)) res_d.alt_offset = 8'hFF;
      else res_d.alt_offset = alt_ext[7:0];
      res_d.overflow    = limit_out;
      out_valid_d       = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SCAN_BETWEEN;
      tn_q        <= 1'b0;
      fp_q        <= 2'd0;
      lp_q        <= '0;
      tok_q       <= '0;
      alt_q       <= '0;
      alt_seen_q  <= 1'b0;
      limit_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        state_q    <= state_d;
        tn_q       <= tn_d;
        fp_q       <= fp_d;
        lp_q       <= lp_d;
        tok_q      <= tok_d;
        alt_q      <= alt_d;
        alt_seen_q <= alt_seen_d;
        limit_q    <= limit_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

[rtl/quoted_argument_tokenizer.sv]
// Top level of the quoted argument tokenizer: front queue and back scanner.
// Each accepted character goes through a queue slot, then the output register, before its result leaves.
// Throughput: one character per cycle without output stalls, set by the back part's scanner.
// Every accepted character yields exactly one result; a zero character closes the line.
// Reset (rst_ni low, asynchronous) empties the queue and output register and clears line state.
// No clearing pass follows reset; the block accepts input in the first cycle after it.
`default_nettype none

module quoted_argument_tokenizer
  import qat_pkg::*;
#(
  parameter int unsigned MAX_TOKENS = 19,
  parameter int unsigned LINE_MAX   = 256
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [7:0]       s_axis_tdata_i,   // [7:0] ch
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // [7:0] tok_char, [8] char_valid, [9] token_end, [14:10] token_count,
  // [15] alt_valid, [23:16] alt_offset, [24] overflow, [31:25] zero
  output logic [RES_W-1:0]      m_axis_tdata_o,
  output logic                  m_axis_tlast_o    // line_end
);

  head_t head;
  logic  pop;
  res_t  res;

  qat_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_ch_i    (s_axis_tdata_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  qat_back #(
    .MAX_TOKENS (MAX_TOKENS),
    .LINE_MAX   (LINE_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  // Pack the result onto the output stream.
  assign m_axis_tdata_o = {7'd0, res.overflow, res.alt_offset, res.alt_valid,
                           res.token_count, res.token_end, res.char_valid, res.tok_char};
  assign m_axis_tlast_o = res.line_end;

endmodule

`default_nettype wire

[rtl/qat_checker.sv]
// Port-level checks for the quoted argument tokenizer, bound to the top level.
`default_nettype none

module qat_checker
  import qat_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid_i,
  input wire logic             s_axis_tready_o,
  input wire logic             m_axis_tvalid_o,
  input wire logic             m_axis_tready_i,
  input wire logic [RES_W-1:0] m_axis_tdata_o,
  input wire logic             m_axis_tlast_o
);

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // The line end item never carries a token character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> !m_axis_tdata_o[8])
    else $error("token character on line end");

  // Without a second argument start the offset reads as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[15] |-> m_axis_tdata_o[23:16] == 8'h00)
    else $error("alt offset set without alt valid");

  // A result never appears without an input request behind it:
  // after an idle, empty block, a result needs a prior input request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o && !$past(s_axis_tvalid_i && s_axis_tready_o) |=> !m_axis_tvalid_o
      || $past(s_axis_tvalid_i && s_axis_tready_o, 2) || $past(s_axis_tvalid_i, 1))
    else $error("result without a request");

  // Padding bits of the result word stay zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[RES_W-1:25] == '0)
    else $error("nonzero padding in result");

endmodule

bind quoted_argument_tokenizer qat_checker u_qat_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

[dv/quoted_argument_tokenizer_tb.sv]
// Self-checking testbench for the quoted argument tokenizer, with a scanner model and a stream checker.
module quoted_argument_tokenizer_tb;
  import qat_pkg::*;

  localparam int unsigned MAX_TOKENS = 19;
  localparam int unsigned LINE_MAX   = 256;

  // Progress of the first token and the start of the second one.
  typedef enum logic [1:0] {
    LEAD_NONE,
    LEAD_OPEN,
    LEAD_RESOLVED
  } lead_e;

  // One directed character, with a hand-written result where it is obvious.
  typedef struct {
    logic [7:0] ch;
    bit         typed;
    res_t       res;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             s_tvalid;
  logic             s_tready;
  logic [7:0]       s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [RES_W-1:0] m_tdata;
  logic             m_tlast;

  // Scanner model state.
  scan_e      scan_st;
  logic       tok_nonempty;
  lead_e      first_ph;
  logic [8:0] line_pos;
  logic [5:0] tok_done;
  logic [8:0] alt_pos;
  logic       alt_seen_q;
  logic       limit_q;
  res_t       char_out;

  // Results predicted for accepted requests, oldest first.
  res_t        pending_results[$];
  logic [7:0]  line_buf[$];
  int unsigned errors = 0;
  int unsigned results_checked = 0;
  int unsigned chars_sent = 0;
  int unsigned scanned_items = 0;
  int unsigned lines_sent = 0;
  int unsigned src_idle_pct = 28;
  int unsigned snk_stall_pct = 78;
  int unsigned hold_request = 0;

  // Directed characters: the extremes, every special character and each corner of the scanner.
  stim_row_t directed_rows [25] = '{
    '{CH_NUL,    1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 5'd0, 1'b0, 8'h00, 1'b0}},    // empty line
    '{CH_BANG,   1'b1, '{CH_BANG, 1'b1, 1'b1, 1'b0, 5'd1, 1'b0, 8'h00, 1'b0}},  // lone lead
    '{8'h61,     1'b0, '0},
    '{CH_NUL,    1'b0, '0},
    '{CH_DOLLAR, 1'b1, '{CH_DOLLAR, 1'b1, 1'b1, 1'b0, 5'd1, 1'b0, 8'h00, 1'b0}},
    '{CH_NUL,    1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 5'd1, 1'b0, 8'h00, 1'b0}},
    '{8'hFF,     1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 5'd0, 1'b0, 8'h00, 1'b0}},
    '{CH_TAB,    1'b0, '0},
    '{CH_SPACE,  1'b0, '0},
    '{CH_BSLASH, 1'b0, '0},
    '{CH_QUOTE,  1'b0, '0},                                                     // escaped quote
    '{CH_QUOTE,  1'b0, '0},
    '{CH_SPACE,  1'b0, '0},                                                     // blank in quotes
    '{CH_QUOTE,  1'b0, '0},
    '{CH_BSLASH, 1'b0, '0},
    '{CH_NUL,    1'b0, '0},                                                     // zero after escape
    '{8'h78,     1'b0, '0},
    '{CH_SPACE,  1'b0, '0},
    '{CH_QUOTE,  1'b0, '0},
    '{CH_QUOTE,  1'b0, '0},
    '{CH_SPACE,  1'b0, '0},                                                     // empty token
    '{8'h79,     1'b0, '0},                                                     // ignored
    '{CH_NUL,    1'b0, '0},
    '{CH_QUOTE,  1'b0, '0},
    '{CH_NUL,    1'b0, '0}                                                      // zero in quotes
  };

  quoted_argument_tokenizer #(
    .MAX_TOKENS(MAX_TOKENS),
    .LINE_MAX  (LINE_MAX)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast)
  );

  // Clock with a period of 12.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Return the scanner to the start of a line.
  function automatic void clear_line();
    scan_st      = SCAN_BETWEEN;
    tok_nonempty = 1'b0;
    first_ph     = LEAD_NONE;
    line_pos     = '0;
    tok_done     = '0;
    alt_pos      = '0;
    alt_seen_q   = 1'b0;
    limit_q      = 1'b0;
  endfunction

  // A token character is shown only while the token limit has not been reached.
  function automatic void emit_char(input logic [7:0] c);
    tok_nonempty = 1'b1;
    if (tok_done < MAX_TOKENS) begin
      char_out.tok_char   = c;
      char_out.char_valid = 1'b1;
    end else begin
      limit_q = 1'b1;
    end
  endfunction

  // Close the open token; an empty one ends the list.
  function automatic void finish_token();
    if (tok_nonempty) begin
      if (tok_done < MAX_TOKENS) begin
        tok_done++;
        char_out.token_end = 1'b1;
      end
      scan_st = SCAN_BETWEEN;
    end else begin
      if (first_ph == LEAD_OPEN) begin
        first_ph   = LEAD_RESOLVED;
        alt_seen_q = 1'b0;
      end
      scan_st = SCAN_DONE;
    end
    tok_nonempty = 1'b0;
  endfunction

  // A character inside a token outside quotes: escape, quote or plain.
  function automatic void extend_token(input logic [7:0] c);
    if (c == CH_BSLASH) begin
      scan_st = SCAN_ESCAPE;
    end else if (c == CH_QUOTE) begin
      scan_st = SCAN_QUOTED;
    end else begin
      scan_st = SCAN_TOKEN;
      emit_char(c);
    end
  endfunction

  // Expected result of one line character; advances the scanner model.
  function automatic res_t tokenize_step(input logic [7:0] c);
    logic [8:0] pos;
    logic       blank;
    res_t       r;
    pos      = line_pos;
    blank    = (c == CH_SPACE) || (c == CH_TAB);
    char_out = '0;
    if (c == CH_NUL) begin
      if (scan_st == SCAN_TOKEN || scan_st == SCAN_ESCAPE || scan_st == SCAN_QUOTED)
        finish_token();
    end else begin
      if (line_pos < LINE_MAX) line_pos++;
      if (scan_st == SCAN_DONE) begin
        // Everything up to the zero is dropped.
      end else if (pos >= LINE_MAX) begin
        limit_q = 1'b1;
        if (scan_st != SCAN_BETWEEN) finish_token();
        if (first_ph == LEAD_OPEN) begin
          first_ph   = LEAD_RESOLVED;
          alt_seen_q = 1'b0;
        end
        scan_st = SCAN_DONE;
      end else if (pos == 0 && first_ph == LEAD_NONE && (c == CH_BANG || c == CH_DOLLAR)) begin
        emit_char(c);
        first_ph = LEAD_OPEN;
        finish_token();
      end else begin
        case (scan_st)
          SCAN_BETWEEN: begin
            if (!blank) begin
              if (first_ph == LEAD_NONE) begin
                first_ph = LEAD_OPEN;
              end else if (first_ph == LEAD_OPEN) begin
                first_ph   = LEAD_RESOLVED;
                alt_seen_q = 1'b1;
                alt_pos    = pos;
              end
              extend_token(c);
            end
          end
          SCAN_TOKEN: begin
            if (blank) finish_token();
            else extend_token(c);
          end
          SCAN_ESCAPE: begin
            emit_char(c);
            scan_st = SCAN_TOKEN;
          end
          default: begin
            if (c == CH_QUOTE) scan_st = SCAN_TOKEN;
            else emit_char(c);
          end
        endcase
      end
    end
    r             = char_out;
    r.line_end    = (c == CH_NUL);
    r.token_count = tok_done[4:0];
    r.alt_valid   = alt_seen_q;
    r.alt_offset  = !alt_seen_q ? 8'h00 : (alt_pos > 255) ? 8'hFF : alt_pos[7:0];
    r.overflow    = limit_q;
    if (c == CH_NUL) clear_line();
    return r;
  endfunction

  // Offer one character, entered at a falling edge and left at the falling edge after the request.
  task automatic send_char(input logic [7:0] c, input bit typed, input res_t typed_res);
    res_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (scan_st != SCAN_DONE) scanned_items++;
    chars_sent++;
    r = tokenize_step(c);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  // Hold the sender back until every predicted result has been seen.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_line_buf();
    foreach (line_buf[i]) send_char(line_buf[i], 1'b0, '0);
    send_char(CH_NUL, 1'b0, '0);
    lines_sent++;
  endtask

  // Mostly well-formed lines of words, escapes and quoted groups; some pure noise.
  function automatic void build_line();
    int unsigned k;
    logic [7:0]  c;
    line_buf.delete();
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(24, 1)) line_buf.push_back(8'($urandom_range(255, 1)));
      return;
    end
    if ($urandom_range(99) < 20) line_buf.push_back(CH_SPACE);
    if ($urandom_range(99) < 15) line_buf.push_back($urandom_range(1) ? CH_BANG : CH_DOLLAR);
    repeat ($urandom_range(6)) begin
      repeat ($urandom_range(3, 1)) begin
        k = $urandom_range(99);
        if (k < 55) begin
          repeat ($urandom_range(4, 1)) begin
            c = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 128))
                                         : 8'($urandom_range(126, 33));
            line_buf.push_back((c == CH_QUOTE || c == CH_BSLASH) ? 8'h7A : c);
          end
        end else if (k < 75) begin
          line_buf.push_back(CH_BSLASH);
          line_buf.push_back(8'($urandom_range(255, 1)));
        end else if (k < 95) begin
          line_buf.push_back(CH_QUOTE);
          repeat ($urandom_range(5)) begin
            c = 8'($urandom_range(255, 1));
            line_buf.push_back((c == CH_QUOTE) ? CH_SPACE : c);
          end
          line_buf.push_back(CH_QUOTE);
        end else begin
          // Unbalanced quote.
          line_buf.push_back(CH_QUOTE);
        end
      end
      repeat ($urandom_range(2, 1)) line_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    end
    if ($urandom_range(99) < 8) line_buf.push_back(CH_BSLASH);
  endfunction

  task automatic send_random_lines(input int unsigned goal);
    int unsigned start_count;
    start_count = scanned_items;
    while (scanned_items - start_count < goal) begin
      build_line();
      send_line_buf();
    end
  endtask

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Result side: random stalls, or a long hold-off when the stimulus asks for one.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Compare every result request with the oldest prediction.
  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && m_tvalid && m_tready) begin
      got.tok_char    = m_tdata[7:0];
      got.char_valid  = m_tdata[8];
      got.token_end   = m_tdata[9];
      got.line_end    = m_tlast;
      got.token_count = m_tdata[14:10];
      got.alt_valid   = m_tdata[15];
      got.alt_offset  = m_tdata[23:16];
      got.overflow    = m_tdata[24];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %h last %b", $time, m_tdata, m_tlast);
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("tok_char", want.tok_char, got.tok_char);
        compare_field("char_valid", want.char_valid, got.char_valid);
        compare_field("token_end", want.token_end, got.token_end);
        compare_field("line_end", want.line_end, got.line_end);
        compare_field("token_count", want.token_count, got.token_count);
        compare_field("alt_valid", want.alt_valid, got.alt_valid);
        compare_field("alt_offset", want.alt_offset, got.alt_offset);
        compare_field("overflow", want.overflow, got.overflow);
        results_checked++;
      end
    end
  end

  // Stimulus: directed table, then random lines under three handshake patterns.
  initial begin : stimulus
    rst_n    = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    clear_line();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_char(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].res);
    send_random_lines(30);
    drain_results();

    // Slow sender, mostly ready receiver.
    src_idle_pct  = 78;
    snk_stall_pct = 28;
    send_random_lines(40);
    drain_results();

    // Full rate; the receiver first holds off so that the block fills and stalls its input.
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_request  = 90;
    line_buf.delete();
    repeat (MAX_TOKENS + 3) begin
      line_buf.push_back(8'($urandom_range(8'h7A, 8'h61)));
      line_buf.push_back(CH_SPACE);
    end
    send_line_buf();
    drain_results();

    // Over-long line with a quoted token open at the length limit.
    line_buf.delete();
    line_buf.push_back(8'h61);
    line_buf.push_back(8'h62);
    while (line_buf.size() < 250) line_buf.push_back(CH_SPACE);
    line_buf.push_back(CH_QUOTE);
    while (line_buf.size() < LINE_MAX + 2) line_buf.push_back(8'($urandom_range(8'h7A, 8'h61)));
    send_line_buf();

    // Over-long line with only one token, so no second start is ever seen.
    line_buf.delete();
    line_buf.push_back(8'h78);
    while (line_buf.size() < LINE_MAX + 2) line_buf.push_back(CH_SPACE);
    send_line_buf();

    send_random_lines(30);
    drain_results();
    repeat (8) @(posedge clk);

    $display("Covered %0d lines, %0d characters (%0d scanned) and %0d checked results.",
             lines_sent, chars_sent, scanned_items, results_checked);
    $display("Included slow sender, slow receiver, full rate, a long receiver hold-off, "
             , "too many tokens and over-long lines.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #6000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
